FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the payload power sequencer.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pps_pkg.sv
// Package for the payload power sequencer: payload types, state struct,
// codes and the per-step action table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

    // Step numbering
    localparam logic [5:0] NUM_STEPS     = 6'd38;
    localparam logic [5:0] LAST_STEP     = 6'd37;
    localparam logic [5:0] STEP_IDLE     = 6'd0;
    localparam logic [5:0] STEP_BEGIN    = 6'd1;
    localparam logic [5:0] STEP_TRANSFER = 6'd35;

    // Enable bits: camera, flash, servo, FPGA, PWM
    localparam logic [4:0] EN_NONE  = 5'b00000;
    localparam logic [4:0] EN_CAM   = 5'b00001;
    localparam logic [4:0] EN_FLASH = 5'b00010;
    localparam logic [4:0] EN_SERVO = 5'b00100;
    localparam logic [4:0] EN_FPGA  = 5'b01000;
    localparam logic [4:0] EN_PWM   = 5'b10000;
    localparam logic [4:0] EN_ALL   = 5'b11111;

    // Servo targets
    localparam logic [1:0] SERVO_BLACK_BODY = 2'd0;
    localparam logic [1:0] SERVO_FILTER_A   = 2'd1;
    localparam logic [1:0] SERVO_FILTER_B   = 2'd2;
    localparam logic [1:0] SERVO_KEEP       = 2'd3;

    // Input kinds and command function codes
    localparam logic       KIND_TICK   = 1'b0;
    localparam logic [7:0] FN_ABORT    = 8'h00;
    localparam logic [7:0] FN_STATUS   = 8'h02;
    localparam logic [7:0] FN_BEGIN    = 8'h03;
    localparam logic [7:0] FN_TRANSFER = 8'h04;
    localparam logic [7:0] FN_ORIENT   = 8'h05;
    localparam logic [7:0] STATUS_OFF  = 8'h00;
    localparam logic [7:0] STATUS_ON   = 8'hFF;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUARTER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUTTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT    = 3'd4;

    typedef enum logic [2:0] {
        DL_QUARTER,
        DL_SHUTTER,
        DL_MOVE,
        DL_ONE,
        DL_BOOT,
        DL_STOP
    } t_delay_sel;

    typedef struct packed {
        logic       kind;
        logic [7:0] function_code;
        logic [7:0] status_byte;
    } t_in_item;

    typedef struct packed {
        logic [5:0] step_index;
        logic       camera_power;
        logic       flash_power;
        logic       servo_power;
        logic       fpga_power;
        logic       pwm_active;
        logic [1:0] servo_target;
        logic       timer_running;
        logic       send_ack;
        logic       send_status;
    } t_out_item;

    typedef struct packed {
        logic [15:0] ticks_quarter_second;
        logic [15:0] ticks_shutter_wait;
        logic [15:0] ticks_servo_move;
        logic [15:0] ticks_one_second;
        logic [15:0] ticks_boot_wait;
    } t_cfg_regs;

    typedef struct packed {
        logic [5:0]  step;
        logic [15:0] tick_count;
        logic [15:0] delay_limit;
        logic [4:0]  enables;
        logic [1:0]  servo;
        logic        running;
        logic        updates_en;
    } t_seq_state;

    typedef struct packed {
        logic ack;
        logic stat;
    } t_msg_flags;

    typedef struct packed {
        logic [4:0] on;
        logic [4:0] off;
        logic [1:0] servo;
        t_delay_sel delay;
    } t_step_action;

    // Action taken when leaving a step
    function automatic t_step_action step_action(input logic [5:0] s);
        t_step_action a;
        unique case (s)
            6'd0:
                a = '{EN_CAM | EN_FLASH, EN_PWM, SERVO_KEEP, DL_BOOT};
            6'd1:
                a = '{EN_FPGA, EN_NONE, SERVO_KEEP, DL_QUARTER};
            6'd2:
                a = '{EN_SERVO | EN_PWM, EN_NONE, SERVO_BLACK_BODY, DL_MOVE};
            6'd3, 6'd7, 6'd18, 6'd29:
                a = '{EN_NONE, EN_PWM, SERVO_KEEP, DL_SHUTTER};
            6'd4:
                a = '{EN_PWM, EN_NONE, SERVO_FILTER_A, DL_MOVE};
            6'd5, 6'd9, 6'd16, 6'd20, 6'd27, 6'd31:
                a = '{EN_NONE, EN_PWM, SERVO_KEEP, DL_QUARTER};
            6'd6, 6'd10, 6'd17, 6'd21, 6'd28, 6'd32:
                a = '{EN_PWM, EN_NONE, SERVO_BLACK_BODY, DL_MOVE};
            6'd8, 6'd19, 6'd30:
                a = '{EN_PWM, EN_NONE, SERVO_FILTER_B, DL_MOVE};
            6'd11, 6'd22:
                a = '{EN_NONE, EN_ALL, SERVO_KEEP, DL_QUARTER};
            6'd12, 6'd23:
                a = '{EN_CAM | EN_FLASH, EN_NONE, SERVO_KEEP, DL_BOOT};
            6'd13, 6'd24:
                a = '{EN_FPGA, EN_NONE, SERVO_KEEP, DL_ONE};
            6'd14, 6'd25:
                a = '{EN_NONE, EN_NONE, SERVO_KEEP, DL_SHUTTER};
            6'd15, 6'd26:
                a = '{EN_SERVO | EN_PWM, EN_NONE, SERVO_FILTER_A, DL_MOVE};
            6'd33:
                a = '{EN_NONE, EN_ALL, SERVO_KEEP, DL_STOP};
            6'd34:
                a = '{EN_FLASH, EN_CAM, SERVO_KEEP, DL_QUARTER};
            6'd35, 6'd36:
                a = '{EN_NONE, EN_NONE, SERVO_KEEP, DL_QUARTER};
            6'd37:
                a = '{EN_NONE, EN_CAM | EN_FLASH | EN_SERVO | EN_FPGA, SERVO_KEEP, DL_STOP};
            default:
                a = '{EN_NONE, EN_NONE, SERVO_KEEP, DL_STOP};
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/payload_power_sequencer_core.sv
// Top level of the payload power sequencer: input register, state update,
// result register and configuration port. Depends on pps_pkg, pps_cfg,
// pps_next and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel: i_in_valid / o_in_stall carry one t_in_item per transfer,
//   either a timer tick or an already checked command. Output channel:
//   o_out_valid / i_out_stall carry exactly one t_out_item per input item,
//   giving the sequencer state after that item plus the ack/status flags.
//   A transfer happens on a rising edge with valid high and stall low.
//   The result passes through the input register, then the state update into
//   the result register. Throughput: one item per cycle while the receiver
//   does not stall; the state update is a single table lookup, one saturating
//   16-bit increment and magnitude and equality compares, so nothing iterates.
//   When the receiver stalls, the result register holds; one more item can
//   wait in the input register, after which o_in_stall rises.
//   Reset (i_rst_n low, synchronous) empties both registers, returns the
//   sequencer to step 0 with all supplies off and the timer stopped, and
//   loads the default delay tick counts. Configuration writes through
//   i_cfg_we / i_cfg_index / i_cfg_data take effect at the next delay load.
module payload_power_sequencer_core (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire pps_pkg::t_in_item          i_in_data,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output pps_pkg::t_out_item              o_out_data,
    input  wire                             i_cfg_we,
    input  wire [pps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [15:0]                      i_cfg_data
);
    import pps_pkg::*;

    `include "assert_macros.svh"

    logic       r_in_valid;
    t_in_item   r_in;
    t_seq_state r_state;
    t_seq_state n_state;
    t_msg_flags n_flags;
    logic       r_out_valid;
    t_out_item  r_out;
    t_out_item  n_out;
    t_cfg_regs  cfg;
    logic       advance;
    logic       in_load;

    // Delay tick counts
    pps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // State update for the item held in the input register
    pps_next u_next (
        .i_state (r_state),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_state (n_state),
        .o_flags (n_flags)
    );

    // Advance the held item when the result register is empty or draining
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_load    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload holds while the input register is stalled
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.step        <= STEP_IDLE;
            r_state.tick_count  <= '0;
            r_state.delay_limit <= '0;
            r_state.enables     <= EN_NONE;
            r_state.servo       <= SERVO_BLACK_BODY;
            r_state.running     <= 1'b0;
            r_state.updates_en  <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Build the result from the updated state
    always_comb begin
        n_out.step_index    = n_state.step;
        n_out.camera_power  = |(n_state.enables & EN_CAM);
        n_out.flash_power   = |(n_state.enables & EN_FLASH);
        n_out.servo_power   = |(n_state.enables & EN_SERVO);
        n_out.fpga_power    = |(n_state.enables & EN_FPGA);
        n_out.pwm_active    = |(n_state.enables & EN_PWM);
        n_out.servo_target  = n_state.servo;
        n_out.timer_running = n_state.running;
        n_out.send_ack      = n_flags.ack;
        n_out.send_status   = n_flags.stat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The timer only runs on a step that has an action
    `ASSERT_IMPLIES(a_run_step_valid, i_clk, i_rst_n, r_state.running, r_state.step < NUM_STEPS, "timer running on an unreachable step")

    // Ack and status come from disjoint causes
    `ASSERT_IMPLIES(a_flags_exclusive, i_clk, i_rst_n, r_out_valid, !(r_out.send_ack && r_out.send_status), "ack and status raised together")

    // A tick while stopped leaves the state untouched
    `ASSERT_NEXT(a_idle_tick_hold, i_clk, i_rst_n, advance && (r_in.kind == KIND_TICK) && !r_state.running, r_state == $past(r_state), "state changed on a tick while stopped")

    // A full input register with a blocked result must push back
    `ASSERT_IMPLIES(a_backpressure, i_clk, i_rst_n, r_in_valid && r_out_valid && i_out_stall, o_in_stall, "input not stalled while both registers are full")

endmodule

`default_nettype wire

FILE: rtl/pps_cfg.sv
// Delay configuration registers of the payload power sequencer.
// Depends on pps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pps_cfg (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [pps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [15:0]                      i_cfg_data,
    output pps_pkg::t_cfg_regs              o_cfg
);
    import pps_pkg::*;

    t_cfg_regs r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_quarter_second <= 16'd1;
            r_cfg.ticks_shutter_wait   <= 16'd2;
            r_cfg.ticks_servo_move     <= 16'd3;
            r_cfg.ticks_one_second     <= 16'd4;
            r_cfg.ticks_boot_wait      <= 16'd16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_QUARTER: r_cfg.ticks_quarter_second <= i_cfg_data;
                CFG_SHUTTER: r_cfg.ticks_shutter_wait   <= i_cfg_data;
                CFG_MOVE:    r_cfg.ticks_servo_move     <= i_cfg_data;
                CFG_ONE:     r_cfg.ticks_one_second     <= i_cfg_data;
                CFG_BOOT:    r_cfg.ticks_boot_wait      <= i_cfg_data;
                default: ;  // writes outside the register list drop
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: rtl/pps_next.sv
// Next-state logic of the payload power sequencer: one tick or command
// applied to the current state. Depends on pps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pps_next (
    input  wire pps_pkg::t_seq_state i_state,
    input  wire pps_pkg::t_in_item   i_item,
    input  wire pps_pkg::t_cfg_regs  i_cfg,
    output pps_pkg::t_seq_state      o_state,
    output pps_pkg::t_msg_flags      o_flags
);
    import pps_pkg::*;

    t_step_action act;
    logic [15:0]  cnt_inc;

    assign act     = step_action(i_state.step);
    assign cnt_inc = (i_state.tick_count != CNT_MAX) ? i_state.tick_count + 16'd1
                                                      : i_state.tick_count;

    always_comb begin
        o_state = i_state;
        o_flags = '0;
        if (i_item.kind == KIND_TICK) begin
            if (i_state.running) begin
                o_state.tick_count = cnt_inc;
                if (cnt_inc >= i_state.delay_limit) begin
                    o_state.tick_count = '0;
                    if (i_state.step < NUM_STEPS) begin
                        o_state.enables = (i_state.enables & ~act.off) | act.on;
                        if (act.servo != SERVO_KEEP) begin
                            o_state.servo = act.servo;
                        end
                        unique case (act.delay)
                            DL_QUARTER: o_state.delay_limit = i_cfg.ticks_quarter_second;
                            DL_SHUTTER: o_state.delay_limit = i_cfg.ticks_shutter_wait;
                            DL_MOVE:    o_state.delay_limit = i_cfg.ticks_servo_move;
                            DL_ONE:     o_state.delay_limit = i_cfg.ticks_one_second;
                            DL_BOOT:    o_state.delay_limit = i_cfg.ticks_boot_wait;
                            default:    o_state.running     = 1'b0;
                        endcase
                        o_state.step = (i_state.step == LAST_STEP) ? STEP_IDLE
                                                                    : i_state.step + 6'd1;
                    end
                    o_flags.stat = i_state.updates_en;
                end
            end
        end else begin
            unique case (i_item.function_code)
                FN_ABORT: begin
                    o_state.step    = STEP_IDLE;
                    o_state.enables = EN_NONE;
                    o_state.running = 1'b0;
                    o_flags.ack     = 1'b1;
                end
                FN_STATUS: begin
                    if (i_item.status_byte == STATUS_OFF) begin
                        o_state.updates_en = 1'b0;
                    end else if (i_item.status_byte == STATUS_ON) begin
                        o_state.updates_en = 1'b1;
                    end
                    o_flags.stat = 1'b1;
                end
                FN_BEGIN: begin
                    o_state.enables     = (i_state.enables | EN_CAM | EN_FLASH) & ~EN_PWM;
                    o_state.delay_limit = i_cfg.ticks_boot_wait;
                    o_state.step        = STEP_BEGIN;
                    o_state.running     = 1'b1;
                    o_flags.ack         = 1'b1;
                end
                FN_TRANSFER: begin
                    o_state.enables     = (i_state.enables | EN_FLASH) & ~EN_CAM;
                    o_state.delay_limit = i_cfg.ticks_quarter_second;
                    o_state.step        = STEP_TRANSFER;
                    o_state.running     = 1'b1;
                    o_flags.ack         = 1'b1;
                end
                FN_ORIENT: begin
                    o_flags.ack = 1'b1;
                end
                default: ;  // other codes change nothing
            endcase
        end
    end

endmodule

`default_nettype wire
